FILE: rtl/kpq_pkg.sv
// Package for the keyed priority queue: operation codes and controller/datapath handshake types.
package kpq_pkg;

   localparam int KeyWidth   = 16;
   localparam int PrioWidth  = 16;
   localparam int CountWidth = 5;

   localparam logic [1:0] OP_INSERT     = 2'd0;
   localparam logic [1:0] OP_REMOVE_MAX = 2'd1;
   localparam logic [1:0] OP_UPDATE     = 2'd2;
   localparam logic [1:0] OP_REMOVE_KEY = 2'd3;

   typedef struct packed {
      logic latch;
      logic find;
      logic take;
      logic take_head;
      logic capture;
      logic cmp;
      logic put;
      logic set_ok;
   } kpq_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       hit_any;
      logic       empty;
      logic       full;
   } kpq_sts_type;

endpackage

FILE: rtl/kpq_if.sv
// Request and response channel interfaces of the keyed priority queue.
interface kpq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [15:0]        key;
   logic signed [15:0] priority_req;

   modport source (output valid, operation, key, priority_req, input ready);
   modport sink (input valid, operation, key, priority_req, output ready);
endinterface

interface kpq_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic [15:0]        removed_key;
   logic signed [15:0] removed_priority;
   logic               top_valid;
   logic [15:0]        top_key;
   logic signed [15:0] top_priority;
   logic [4:0]         entry_count;

   modport source (output valid, ok, removed_key, removed_priority, top_valid, top_key,
                   top_priority, entry_count, input ready);
   modport sink (input valid, ok, removed_key, removed_priority, top_valid, top_key,
                 top_priority, entry_count, output ready);
endinterface

FILE: rtl/keyed_priority_queue.sv
// Top level of the keyed priority queue: sorted cell array with its sequencing controller.
// The queue holds up to CAPACITY entries with unique 16-bit keys, sorted by descending
// signed priority; equal priorities keep arrival order.
// A request transfer on req_ch carries an operation (insert, remove maximum, change
// priority, remove by key), a key and a priority. Every request yields exactly one
// response transfer on rsp_ch with the success flag, the removed entry, the head
// entry and the entry count after the operation.
// The response is valid once the request has passed its working steps: a successful insert
// or priority change goes through key search, removal (priority change only), priority
// compare and placement; every other request goes through key search and, if it
// succeeds, removal.
// The block holds one request at a time and accepts the next one in the cycle after the
// response transfer, so it takes no new request while one is in progress or while its
// response waits for rsp_ch.ready.
// While the response is not taken, the response fields hold still and no new request
// is accepted.
// Reset empties the queue; no clearing pass is needed.
module keyed_priority_queue #(
   parameter int CAPACITY = 16
) (
   input logic      clock,
   input logic      reset,
   kpq_req_if.sink   req_ch,
   kpq_rsp_if.source rsp_ch
);
   import kpq_pkg::*;

   kpq_cmd_type cmd;
   kpq_sts_type sts;

   kpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_ch.operation),
      .req_key              (req_ch.key),
      .req_priority_req     (req_ch.priority_req),
      .rsp_ok               (rsp_ch.ok),
      .rsp_removed_key      (rsp_ch.removed_key),
      .rsp_removed_priority (rsp_ch.removed_priority),
      .rsp_top_valid        (rsp_ch.top_valid),
      .rsp_top_key          (rsp_ch.top_key),
      .rsp_top_priority     (rsp_ch.top_priority),
      .rsp_entry_count      (rsp_ch.entry_count)
   );

endmodule

FILE: rtl/kpq_ctrl.sv
// Sequencing state machine of the keyed priority queue.
module kpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  kpq_pkg::kpq_sts_type sts,
   output kpq_pkg::kpq_cmd_type cmd
);
   import kpq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIND = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_FIND;
            end
         end
         S_FIND: begin
            cmd.find = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (sts.op)
               OP_INSERT: begin
                  if (!sts.hit_any && !sts.full) begin
                     state_in = S_CMP;
                  end
               end
               OP_REMOVE_MAX: begin
                  if (!sts.empty) begin
                     cmd.take      = 1'b1;
                     cmd.take_head = 1'b1;
                     cmd.capture   = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
               end
               OP_UPDATE: begin
                  if (sts.hit_any) begin
                     cmd.take = 1'b1;
                     state_in = S_CMP;
                  end
               end
               default: begin
                  if (sts.hit_any) begin
                     cmd.take    = 1'b1;
                     cmd.capture = 1'b1;
                     cmd.set_ok  = 1'b1;
                  end
               end
            endcase
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            cmd.put    = 1'b1;
            cmd.set_ok = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/kpq_datapath.sv
// Sorted cell array with parallel key and priority compares, shift logic and response fields.
module kpq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kpq_pkg::kpq_cmd_type          cmd,
   output kpq_pkg::kpq_sts_type          sts,
   input  logic [1:0]                    req_operation,
   input  logic [kpq_pkg::KeyWidth-1:0]  req_key,
   input  logic signed [kpq_pkg::PrioWidth-1:0] req_priority_req,
   output logic                          rsp_ok,
   output logic [kpq_pkg::KeyWidth-1:0]  rsp_removed_key,
   output logic signed [kpq_pkg::PrioWidth-1:0] rsp_removed_priority,
   output logic                          rsp_top_valid,
   output logic [kpq_pkg::KeyWidth-1:0]  rsp_top_key,
   output logic signed [kpq_pkg::PrioWidth-1:0] rsp_top_priority,
   output logic [kpq_pkg::CountWidth-1:0] rsp_entry_count
);
   import kpq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [KeyWidth-1:0]         key_ff [CAPACITY];
   logic [KeyWidth-1:0]         key_in [CAPACITY];
   logic signed [PrioWidth-1:0] prio_ff [CAPACITY];
   logic signed [PrioWidth-1:0] prio_in [CAPACITY];
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;
   logic [CAPACITY-1:0]         hit_ff;
   logic [CAPACITY-1:0]         hit_in;
   logic [CAPACITY-1:0]         ge_ff;
   logic [CAPACITY-1:0]         ge_in;
   logic [1:0]                  op_ff;
   logic [KeyWidth-1:0]         rkey_ff;
   logic signed [PrioWidth-1:0] rprio_ff;
   logic                        ok_ff;
   logic [KeyWidth-1:0]         rem_key_ff;
   logic [KeyWidth-1:0]         rem_key_in;
   logic signed [PrioWidth-1:0] rem_prio_ff;
   logic signed [PrioWidth-1:0] rem_prio_in;
   logic [CAPACITY-1:0]         sel;
   logic [CAPACITY-1:0]         shl;
   logic [CW+CountWidth-1:0]    count_ext;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit_in[i] = (CW'(i) < count_ff) && (key_ff[i] == rkey_ff);
         ge_in[i]  = (CW'(i) < count_ff) && (prio_ff[i] >= rprio_ff);
      end
      sel = cmd.take_head ? CAPACITY'(1) : hit_ff;
      shl[0] = sel[0];
      for (int i = 1; i < CAPACITY; i++) begin
         shl[i] = shl[i-1] | sel[i];
      end
      rem_key_in  = '0;
      rem_prio_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rem_key_in  = rem_key_in | ({KeyWidth{sel[i]}} & key_ff[i]);
         rem_prio_in = rem_prio_in | ({PrioWidth{sel[i]}} & prio_ff[i]);
      end
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i]  = key_ff[i];
         prio_in[i] = prio_ff[i];
      end
      if (cmd.take) begin
         count_in = count_ff - CW'(1);
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (shl[i]) begin
               key_in[i]  = key_ff[i+1];
               prio_in[i] = prio_ff[i+1];
            end
         end
      end else if (cmd.put) begin
         count_in = count_ff + CW'(1);
         for (int i = 0; i < CAPACITY; i++) begin
            if (!ge_ff[i]) begin
               if (i == 0 || ge_ff[(i == 0) ? 0 : i-1]) begin
                  key_in[i]  = rkey_ff;
                  prio_in[i] = rprio_ff;
               end else begin
                  key_in[i]  = key_ff[(i == 0) ? 0 : i-1];
                  prio_in[i] = prio_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i]  <= key_in[i];
         prio_ff[i] <= prio_in[i];
      end
      if (cmd.latch) begin
         op_ff       <= req_operation;
         rkey_ff     <= req_key;
         rprio_ff    <= req_priority_req;
         ok_ff       <= 1'b0;
         rem_key_ff  <= '0;
         rem_prio_ff <= '0;
      end else begin
         if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.capture) begin
            rem_key_ff  <= rem_key_in;
            rem_prio_ff <= rem_prio_in;
         end
      end
      if (cmd.find) begin
         hit_ff <= hit_in;
      end
      if (cmd.cmp) begin
         ge_ff <= ge_in;
      end
   end

   assign sts.op      = op_ff;
   assign sts.hit_any = |hit_ff;
   assign sts.empty   = (count_ff == '0);
   assign sts.full    = (count_ff == CW'(CAPACITY));

   assign count_ext            = {{CountWidth{1'b0}}, count_ff};
   assign rsp_ok               = ok_ff;
   assign rsp_removed_key      = rem_key_ff;
   assign rsp_removed_priority = rem_prio_ff;
   assign rsp_top_valid        = (count_ff != '0);
   assign rsp_top_key          = rsp_top_valid ? key_ff[0] : '0;
   assign rsp_top_priority     = rsp_top_valid ? prio_ff[0] : '0;
   assign rsp_entry_count      = count_ext[CountWidth-1:0];

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for keyed_priority_queue with a driver, a monitor and a queue predictor.
`timescale 1ns / 100ps

module tb_top;
   import kpq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_SEGMENTS = 8;
   localparam int SEGMENT_ITEMS = 163;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]         op;
      logic [15:0]        key;
      logic signed [15:0] prio;
      int                 gap_pct;
      int                 stall_pct;
      bit                 drain;
   } pending_req_type;

   typedef struct packed {
      logic               ok;
      logic [15:0]        removed_key;
      logic signed [15:0] removed_prio;
      logic               top_valid;
      logic [15:0]        top_key;
      logic signed [15:0] top_prio;
      logic [4:0]         count;
   } queue_result_type;

   logic clock;
   logic reset;

   kpq_req_if req_ch ();
   kpq_rsp_if rsp_ch ();

   keyed_priority_queue #(
      .CAPACITY(QUEUE_DEPTH)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   pending_req_type    pending_reqs[$];
   queue_result_type   predicted_rsps[$];
   pending_req_type    next_req;
   queue_result_type   want_rsp;
   queue_result_type   got_rsp;
   logic [15:0]        held_key [QUEUE_DEPTH];
   logic signed [15:0] held_prio [QUEUE_DEPTH];
   int                 held_count;
   logic [15:0]        key_pool [20];
   int                 rsp_stall_pct;
   int                 mismatches;
   int                 cycle_count;

   always #5 clock = ~clock;

   function automatic void take_out(input int idx);
      int i;
      for (i = idx; i + 1 < held_count; i++) begin
         held_key[i] = held_key[i + 1];
         held_prio[i] = held_prio[i + 1];
      end
      held_count--;
   endfunction

   function automatic void place_entry(input logic [15:0] key, input logic signed [15:0] prio);
      int pos;
      int i;
      pos = 0;
      while (pos < held_count && held_prio[pos] >= prio) pos++;
      for (i = held_count; i > pos; i--) begin
         held_key[i] = held_key[i - 1];
         held_prio[i] = held_prio[i - 1];
      end
      held_key[pos] = key;
      held_prio[pos] = prio;
      held_count++;
   endfunction

   function automatic queue_result_type apply_queue_op(input logic [1:0] op,
                                                       input logic [15:0] key,
                                                       input logic signed [15:0] prio);
      queue_result_type r;
      int idx;
      int i;
      r = '0;
      idx = held_count;
      for (i = held_count - 1; i >= 0; i--) begin
         if (held_key[i] == key) idx = i;
      end
      case (op)
         OP_INSERT: begin
            if (idx == held_count && held_count < QUEUE_DEPTH) begin
               place_entry(key, prio);
               r.ok = 1'b1;
            end
         end
         OP_REMOVE_MAX: begin
            if (held_count > 0) begin
               r.removed_key = held_key[0];
               r.removed_prio = held_prio[0];
               take_out(0);
               r.ok = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (idx < held_count) begin
               take_out(idx);
               place_entry(key, prio);
               r.ok = 1'b1;
            end
         end
         OP_REMOVE_KEY: begin
            if (idx < held_count) begin
               r.removed_key = held_key[idx];
               r.removed_prio = held_prio[idx];
               take_out(idx);
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      if (held_count > 0) begin
         r.top_valid = 1'b1;
         r.top_key = held_key[0];
         r.top_prio = held_prio[0];
      end
      r.count = held_count[4:0];
      return r;
   endfunction

   task automatic queue_req(input logic [1:0] op, input logic [15:0] key,
                            input logic signed [15:0] prio, input int gap_pct,
                            input int stall_pct, input bit drain);
      pending_req_type item;
      item.op = op;
      item.key = key;
      item.prio = prio;
      item.gap_pct = gap_pct;
      item.stall_pct = stall_pct;
      item.drain = drain;
      pending_reqs.push_back(item);
   endtask

   function automatic logic signed [15:0] pick_priority();
      int sel;
      int v;
      sel = $urandom_range(99);
      if (sel < 40) begin
         v = $urandom_range(4);
         return 16'(v - 2);
      end else if (sel < 45) begin
         return 16'sh8000;
      end else if (sel < 50) begin
         return 16'sh7fff;
      end
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [15:0] pick_key();
      if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
      return key_pool[$urandom_range(19)];
   endfunction

   function automatic logic [1:0] pick_op(input bit filling);
      int sel;
      sel = $urandom_range(99);
      if (filling) begin
         if (sel < 60) return OP_INSERT;
         if (sel < 70) return OP_REMOVE_MAX;
         if (sel < 85) return OP_UPDATE;
         return OP_REMOVE_KEY;
      end
      if (sel < 20) return OP_INSERT;
      if (sel < 55) return OP_REMOVE_MAX;
      if (sel < 70) return OP_UPDATE;
      return OP_REMOVE_KEY;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted_rsps.push_back(apply_queue_op(req_ch.operation, req_ch.key,
                                                    req_ch.priority_req));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 &&
                (!pending_reqs[0].drain || predicted_rsps.size() == 0) &&
                $urandom_range(99) >= pending_reqs[0].gap_pct) begin
               next_req = pending_reqs.pop_front();
               rsp_stall_pct = next_req.stall_pct;
               req_ch.valid <= 1'b1;
               req_ch.operation <= next_req.op;
               req_ch.key <= next_req.key;
               req_ch.priority_req <= next_req.prio;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response transfer at cycle %0d",
                                              cycle_count);
            end else begin
               want_rsp = predicted_rsps.pop_front();
               got_rsp = '{ok: rsp_ch.ok, removed_key: rsp_ch.removed_key,
                           removed_prio: rsp_ch.removed_priority,
                           top_valid: rsp_ch.top_valid, top_key: rsp_ch.top_key,
                           top_prio: rsp_ch.top_priority, count: rsp_ch.entry_count};
               if (got_rsp.ok !== want_rsp.ok ||
                   got_rsp.removed_key !== want_rsp.removed_key ||
                   got_rsp.removed_prio !== want_rsp.removed_prio ||
                   got_rsp.top_valid !== want_rsp.top_valid ||
                   got_rsp.top_key !== want_rsp.top_key ||
                   got_rsp.top_prio !== want_rsp.top_prio ||
                   got_rsp.count !== want_rsp.count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"mismatch at cycle %0d: expected ok=%0d rem=%h/%0d ",
                               "top=%0d %h/%0d n=%0d"},
                              cycle_count, want_rsp.ok, want_rsp.removed_key,
                              want_rsp.removed_prio, want_rsp.top_valid, want_rsp.top_key,
                              want_rsp.top_prio, want_rsp.count);
                     $display("   actual ok=%0d rem=%h/%0d top=%0d %h/%0d n=%0d",
                              got_rsp.ok, got_rsp.removed_key, got_rsp.removed_prio,
                              got_rsp.top_valid, got_rsp.top_key, got_rsp.top_prio,
                              got_rsp.count);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keyed_priority_queue regression: fail");
         $finish;
      end
   end

   initial begin
      int i;
      int s;
      int gap_pct;
      int stall_pct;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = OP_INSERT;
      req_ch.key = '0;
      req_ch.priority_req = '0;
      rsp_ch.ready = 1'b0;
      held_count = 0;
      rsp_stall_pct = 0;
      mismatches = 0;
      cycle_count = 0;

      // Empty queue, extremes, duplicate key, ties and same-priority update.
      queue_req(OP_REMOVE_MAX, 16'h0000, 16'sh0000, 0, 0, 0);
      queue_req(OP_REMOVE_KEY, 16'hffff, 16'sh0000, 0, 0, 0);
      queue_req(OP_UPDATE, 16'h0000, 16'sh7fff, 0, 0, 0);
      queue_req(OP_INSERT, 16'h0000, 16'sh8000, 0, 0, 0);
      queue_req(OP_INSERT, 16'hffff, 16'sh7fff, 0, 0, 0);
      queue_req(OP_INSERT, 16'h0000, 16'sh0005, 0, 0, 0);
      queue_req(OP_INSERT, 16'h1234, 16'sh0000, 0, 0, 0);
      queue_req(OP_INSERT, 16'h5678, 16'sh0000, 0, 0, 0);
      queue_req(OP_UPDATE, 16'h1234, 16'sh0000, 0, 0, 0);
      queue_req(OP_UPDATE, 16'habcd, 16'sh0001, 0, 0, 0);
      queue_req(OP_REMOVE_KEY, 16'hffff, 16'sh7fff, 0, 0, 0);
      queue_req(OP_REMOVE_MAX, 16'h0000, 16'sh0000, 0, 0, 0);
      for (i = 0; i < 14; i++) begin
         queue_req(OP_INSERT, 16'h0100 + 16'(i * 16'h0111), pick_priority(), 0, 0, 0);
      end
      queue_req(OP_INSERT, 16'h7777, 16'sh7fff, 0, 0, 0);

      for (s = 0; s < RANDOM_SEGMENTS; s++) begin
         case (s % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 48; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 48; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase
         key_pool[0] = 16'h0000;
         key_pool[1] = 16'hffff;
         for (i = 2; i < 20; i++) key_pool[i] = 16'($urandom_range(65535));
         for (i = 0; i < SEGMENT_ITEMS; i++) begin
            queue_req(pick_op(((i / 40) % 2) == 0), pick_key(), pick_priority(),
                      gap_pct, stall_pct, i == 0);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_ch.valid || predicted_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_rsps.size() == 0) begin
         $display("keyed_priority_queue regression: pass");
      end else begin
         $display("keyed_priority_queue regression: fail");
      end
      $finish;
   end

endmodule

FILE: keyed_priority_queue.f
rtl/kpq_pkg.sv
rtl/kpq_if.sv
rtl/kpq_ctrl.sv
rtl/kpq_datapath.sv
rtl/keyed_priority_queue.sv
dv/tb_top.sv
